### rtl/core/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// shared types and constants of the sorted key table
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CMD_W     = 2;
  localparam int KEY_W     = 64;
  localparam int PAY_W     = 16;
  localparam int POS_W     = 6;
  localparam int CNT_OUT_W = 7;
  localparam int WORD_W    = KEY_W + PAY_W;

  // operation codes
  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN,
    ST_PLACE,
    ST_DONE
  } skt_state_t;

  // key compare result, stored key against request key
  typedef struct packed {
    logic gt;
    logic eq;
  } skt_cmp_t;

endpackage

### rtl/core/skt_in_if.sv
// ----------------------------------------------------------------------------
// skt_in_if
// request channel: command, key and payload with valid/ready
// ----------------------------------------------------------------------------
interface skt_in_if;
  import skt_pkg::*;

  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [KEY_W-1:0] key;
  logic [PAY_W-1:0] payload;

  modport source (output valid, output cmd, output key, output payload, input ready);
  modport sink   (input valid, input cmd, input key, input payload, output ready);
endinterface

### rtl/core/skt_out_if.sv
// ----------------------------------------------------------------------------
// skt_out_if
// result channel: status, position, payload and entry count with valid/ready
// ----------------------------------------------------------------------------
interface skt_out_if;
  import skt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 ok;
  logic [POS_W-1:0]     position;
  logic [PAY_W-1:0]     payload_out;
  logic [CNT_OUT_W-1:0] count;

  modport source (output valid, output ok, output position, output payload_out,
                  output count, input ready);
  modport sink   (input valid, input ok, input position, input payload_out,
                  input count, output ready);
endinterface

### rtl/core/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table
// ordered key/payload table kept in ascending key order in one ram, walked
// one entry per cycle through a single comparator
//
// walk: a search hit ends the walk at the matching entry; search miss and
//   remove walk every entry; insert walks down from the top entry to its
//   position and then places, into an empty table it only places; full
//   insert, empty search/remove and unused codes go straight to done
// throughput: one transaction at a time, set by the one-entry-per-cycle
//   ram walk and held in done by out_ch.ready; in_ch.ready is high only while idle
// reset: synchronous active-low rst_n empties the table; ram contents are
//   not cleared, entries at or above the count are never read
// ----------------------------------------------------------------------------
module sorted_key_table #(
  parameter int CAPACITY = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  skt_in_if.sink           in_ch,
  skt_out_if.source        out_ch
);
  import skt_pkg::*;

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_EXT = IDX_W + POS_W;
  localparam int CNT_EXT = CNT_W + CNT_OUT_W;

  // control state
  skt_state_t           state_r, state_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 issue_r, issue_nxt;     // reads still to be issued
  logic                 dv_r, dv_nxt;           // ram read data valid this cycle
  logic                 found_r, found_nxt;     // first match already seen
  logic                 out_valid_r, out_valid_nxt;

  // latched request
  logic [CMD_W-1:0]     cmd_r;
  logic [KEY_W-1:0]     key_r;
  logic [PAY_W-1:0]     pay_r;

  // walk pointers
  logic [IDX_W-1:0]     rd_ptr_r, rd_ptr_nxt;   // next address to read
  logic [IDX_W-1:0]     da_r, da_nxt;           // address of current read data

  // pending result
  logic                 rok_r, rok_nxt;
  logic [IDX_W-1:0]     rpos_r, rpos_nxt;
  logic [PAY_W-1:0]     rpay_r, rpay_nxt;

  // output register
  logic                 out_ok_r, out_ok_nxt;
  logic [POS_W-1:0]     out_pos_r, out_pos_nxt;
  logic [PAY_W-1:0]     out_pay_r, out_pay_nxt;
  logic [CNT_OUT_W-1:0] out_cnt_r, out_cnt_nxt;

  // ram port
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [WORD_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [WORD_W-1:0]    ram_rdata;

  logic                 in_fire;
  logic                 stop;                   // walk finished this cycle
  logic                 hit_now;                // current entry is the first match
  logic                 last;                   // current entry is the top one
  logic                 out_free;
  logic [IDX_W-1:0]     cnt_last;
  logic [KEY_W-1:0]     rd_key;
  logic [PAY_W-1:0]     rd_pay;
  logic [POS_EXT-1:0]   pos_ext;
  logic [CNT_EXT-1:0]   cnt_ext;
  skt_cmp_t             cmp;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.ok          = out_ok_r;
  assign out_ch.position    = out_pos_r;
  assign out_ch.payload_out = out_pay_r;
  assign out_ch.count       = out_cnt_r;

  assign rd_key   = ram_rdata[WORD_W-1:PAY_W];
  assign rd_pay   = ram_rdata[PAY_W-1:0];
  assign cnt_last = IDX_W'(cnt_r - CNT_W'(1));
  assign last     = (da_r == cnt_last);
  assign out_free = !out_valid_r || out_ch.ready;

  // position and count are reported in their low bits
  assign pos_ext  = POS_EXT'(rpos_r);
  assign cnt_ext  = CNT_EXT'(cnt_r);

  skt_ram #(
    .WIDTH (WORD_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (rd_ptr_r),
    .rdata (ram_rdata)
  );

  // the one comparator: stored entry under the walk against the request key
  skt_cmp u_cmp (
    .stored_key (rd_key),
    .req_key    (key_r),
    .res        (cmp)
  );

  // end of walk: insert stops at the first key not greater (walking down)
  // or at the bottom; search stops at the first match; remove and misses
  // stop at the top entry
  always_comb begin
    stop    = 1'b0;
    hit_now = 1'b0;
    if (state_r == ST_RUN && dv_r) begin
      if (cmd_r == CMD_INSERT) begin
        stop = !cmp.gt || (da_r == '0);
      end else begin
        hit_now = !found_r && cmp.eq;
        if (hit_now && cmd_r == CMD_SEARCH) begin
          stop = 1'b1;
        end else begin
          stop = last;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        case (cmd_r)
          CMD_INSERT: begin
            if (cnt_r == CNT_W'(CAPACITY)) begin
              state_nxt = ST_DONE;
            end else if (cnt_r == '0) begin
              state_nxt = ST_PLACE;
            end else begin
              state_nxt = ST_RUN;
            end
          end
          CMD_SEARCH, CMD_REMOVE: begin
            state_nxt = (cnt_r == '0) ? ST_DONE : ST_RUN;
          end
          default: begin
            state_nxt = ST_DONE;
          end
        endcase
      end
      ST_RUN: begin
        if (stop) begin
          state_nxt = (cmd_r == CMD_INSERT) ? ST_PLACE : ST_DONE;
        end
      end
      ST_PLACE: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_nxt       = cnt_r;
    issue_nxt     = issue_r;
    dv_nxt        = 1'b0;
    found_nxt     = found_r;
    rd_ptr_nxt    = rd_ptr_r;
    da_nxt        = da_r;
    rok_nxt       = rok_r;
    rpos_nxt      = rpos_r;
    rpay_nxt      = rpay_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_ok_nxt    = out_ok_r;
    out_pos_nxt   = out_pos_r;
    out_pay_nxt   = out_pay_r;
    out_cnt_nxt   = out_cnt_r;
    ram_we        = 1'b0;
    ram_waddr     = rpos_r;
    ram_wdata     = {key_r, pay_r};
    ram_re        = 1'b0;

    case (state_r)
      ST_SETUP: begin
        rok_nxt   = 1'b0;
        rpos_nxt  = '0;
        rpay_nxt  = '0;
        found_nxt = 1'b0;
        issue_nxt = 1'b0;
        if (cmd_r == CMD_INSERT && cnt_r != '0 && cnt_r != CNT_W'(CAPACITY)) begin
          // insert walks down from the top entry
          rd_ptr_nxt = cnt_last;
          issue_nxt  = 1'b1;
        end else if ((cmd_r == CMD_SEARCH || cmd_r == CMD_REMOVE) && cnt_r != '0) begin
          rd_ptr_nxt = '0;
          issue_nxt  = 1'b1;
        end
      end

      ST_RUN: begin
        // issue side: one read per cycle along the walk
        if (issue_r && !stop) begin
          ram_re = 1'b1;
          dv_nxt = 1'b1;
          da_nxt = rd_ptr_r;
          if (cmd_r == CMD_INSERT) begin
            if (rd_ptr_r == '0) begin
              issue_nxt = 1'b0;
            end else begin
              rd_ptr_nxt = rd_ptr_r - IDX_W'(1);
            end
          end else begin
            if (rd_ptr_r == cnt_last) begin
              issue_nxt = 1'b0;
            end else begin
              rd_ptr_nxt = rd_ptr_r + IDX_W'(1);
            end
          end
        end
        if (stop) begin
          issue_nxt = 1'b0;
        end

        // data side: act on the entry read last cycle
        if (dv_r) begin
          if (cmd_r == CMD_INSERT) begin
            if (cmp.gt) begin
              // greater key moves up one slot
              ram_we    = 1'b1;
              ram_waddr = da_r + IDX_W'(1);
              ram_wdata = ram_rdata;
              if (da_r == '0) begin
                rpos_nxt = '0;
              end
            end else begin
              rpos_nxt = da_r + IDX_W'(1);
            end
          end else if (hit_now) begin
            found_nxt = 1'b1;
            rok_nxt   = 1'b1;
            rpos_nxt  = da_r;
            rpay_nxt  = rd_pay;
            if (cmd_r == CMD_REMOVE && last) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end else if (found_r && cmd_r == CMD_REMOVE) begin
            // entries above the removed one close the gap
            ram_we    = 1'b1;
            ram_waddr = da_r - IDX_W'(1);
            ram_wdata = ram_rdata;
            if (last) begin
              cnt_nxt = cnt_r - CNT_W'(1);
            end
          end
        end
      end

      ST_PLACE: begin
        ram_we    = 1'b1;
        ram_waddr = rpos_r;
        ram_wdata = {key_r, pay_r};
        rok_nxt   = 1'b1;
        rpay_nxt  = pay_r;
        cnt_nxt   = cnt_r + CNT_W'(1);
      end

      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = rok_r;
          out_pos_nxt   = pos_ext[POS_W-1:0];
          out_pay_nxt   = rpay_r;
          out_cnt_nxt   = cnt_ext[CNT_OUT_W-1:0];
        end
      end

      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      issue_r     <= 1'b0;
      dv_r        <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      issue_r     <= issue_nxt;
      dv_r        <= dv_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_r <= in_ch.cmd;
      key_r <= in_ch.key;
      pay_r <= in_ch.payload;
    end
    rd_ptr_r  <= rd_ptr_nxt;
    da_r      <= da_nxt;
    rok_r     <= rok_nxt;
    rpos_r    <= rpos_nxt;
    rpay_r    <= rpay_nxt;
    out_ok_r  <= out_ok_nxt;
    out_pos_r <= out_pos_nxt;
    out_pay_r <= out_pay_nxt;
    out_cnt_r <= out_cnt_nxt;
  end

  // the table never holds more than its capacity
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // the table is written only while a transaction is being worked
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE || state_r == ST_SETUP) |-> !ram_we)
    else $error("ram write outside a walk");

  // the count moves only during a walk or a placement
  a_cnt_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE || state_r == ST_SETUP) |=> $stable(cnt_r))
    else $error("entry count changed outside a walk");

  // an accepted transaction always starts with the setup step
  a_accept_setup: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_SETUP))
    else $error("accepted transaction did not enter setup");

  // a new result is loaded only when the output slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_pay_r) && $stable(out_cnt_r))
    else $error("pending result overwritten");

endmodule

### rtl/core/skt_ram.sv
// ----------------------------------------------------------------------------
// skt_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module skt_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/skt_cmp.sv
// ----------------------------------------------------------------------------
// skt_cmp
// shared key comparator, used once per entry visited by the walk
// ----------------------------------------------------------------------------
module skt_cmp (
  input  logic [skt_pkg::KEY_W-1:0] stored_key,
  input  logic [skt_pkg::KEY_W-1:0] req_key,
  output skt_pkg::skt_cmp_t         res
);
  import skt_pkg::*;

  always_comb begin
    res.gt = (stored_key > req_key);
    res.eq = (stored_key == req_key);
  end

endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the sorted key table: a directed table of
// transactions, then phased random traffic (fill, drain, mixed) with random
// idle gaps on both channels, every result checked against its typed row or a local model
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import skt_pkg::*;

  localparam int TABLE_DEPTH  = 64;
  localparam int RANDOM_ITEMS = 650;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int TAIL_CYCLES  = 100;
  localparam int KEY_POOL_N   = 16;

  // the one code the block leaves unused
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic                 ok;
    logic [POS_W-1:0]     position;
    logic [PAY_W-1:0]     payload_out;
    logic [CNT_OUT_W-1:0] count;
  } table_result_t;

  typedef struct {
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
    bit               typed;
    table_result_t    res;
  } directed_row_t;

  typedef enum {PH_FILL, PH_DRAIN, PH_MIX} phase_kind_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  skt_in_if  in_ch ();
  skt_out_if out_ch ();

  sorted_key_table #(.CAPACITY(TABLE_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // local copy of the table, kept in ascending key order
  logic [KEY_W-1:0] tbl_keys [TABLE_DEPTH];
  logic [PAY_W-1:0] tbl_pays [TABLE_DEPTH];
  int               tbl_count = 0;

  table_result_t    pending_results [$];
  int               error_count = 0;
  int               cycle_count = 0;
  logic [KEY_W-1:0] key_pool [KEY_POOL_N];
  directed_row_t    dir_rows [$];

  // apply one transaction to the local table and return what the block owes
  function automatic table_result_t apply_table_op(logic [CMD_W-1:0] op,
                                                   logic [KEY_W-1:0] k,
                                                   logic [PAY_W-1:0] p);
    table_result_t r;
    int            slot;
    int            hit;
    r    = '0;
    slot = tbl_count;
    hit  = tbl_count;
    case (op)
      CMD_INSERT: begin
        if (tbl_count < TABLE_DEPTH) begin
          // first strictly greater key, so equal keys stay ahead
          for (int i = 0; i < tbl_count; i++)
            if (slot == tbl_count && tbl_keys[i] > k) slot = i;
          for (int i = tbl_count; i > slot; i--) begin
            tbl_keys[i] = tbl_keys[i-1];
            tbl_pays[i] = tbl_pays[i-1];
          end
          tbl_keys[slot] = k;
          tbl_pays[slot] = p;
          tbl_count++;
          r.ok          = 1'b1;
          r.position    = 6'(slot);
          r.payload_out = p;
        end
      end
      CMD_SEARCH, CMD_REMOVE: begin
        for (int i = 0; i < tbl_count; i++)
          if (hit == tbl_count && tbl_keys[i] == k) hit = i;
        if (hit < tbl_count) begin
          r.ok          = 1'b1;
          r.position    = 6'(hit);
          r.payload_out = tbl_pays[hit];
          if (op == CMD_REMOVE) begin
            for (int i = hit; i + 1 < tbl_count; i++) begin
              tbl_keys[i] = tbl_keys[i+1];
              tbl_pays[i] = tbl_pays[i+1];
            end
            tbl_count--;
          end
        end
      end
      default: ;
    endcase
    r.count = 7'(tbl_count);
    return r;
  endfunction

  // eight-character style key: printable bytes from the top, zero padded
  function automatic logic [KEY_W-1:0] make_name_key();
    logic [KEY_W-1:0] k;
    int               len;
    k   = '0;
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++)
      k[KEY_W-1-8*i -: 8] = 8'($urandom_range(8'h30, 8'h7a));
    return k;
  endfunction

  // on a non-empty table, half of searches and removes aim at stored keys so they hit
  function automatic logic [KEY_W-1:0] pick_key(logic [CMD_W-1:0] op);
    int r;
    r = $urandom_range(0, 99);
    if (op != CMD_INSERT && tbl_count > 0 && r < 50)
      return tbl_keys[$urandom_range(0, tbl_count - 1)];
    if (r < 75) return key_pool[$urandom_range(0, KEY_POOL_N - 1)];
    if (r < 90) return make_name_key();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(phase_kind_t kind);
    int r;
    r = $urandom_range(0, 99);
    case (kind)
      PH_FILL:  return (r < 80) ? CMD_INSERT : (r < 95) ? CMD_SEARCH :
                       (r < 98) ? CMD_REMOVE : CMD_UNUSED;
      PH_DRAIN: return (r < 70) ? CMD_REMOVE : (r < 80) ? CMD_INSERT :
                       (r < 98) ? CMD_SEARCH : CMD_UNUSED;
      default:  return (r < 40) ? CMD_INSERT : (r < 75) ? CMD_SEARCH :
                       (r < 97) ? CMD_REMOVE : CMD_UNUSED;
    endcase
  endfunction

  // sender idle: mostly none or short, now and then long
  function automatic int pick_gap(bit calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  // present one transaction and hold it until accepted; valid stays high
  // so a back-to-back transaction needs no second assignment in the step
  task automatic send_op(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
                         logic [PAY_W-1:0] p, bit typed, table_result_t typed_res);
    table_result_t pred;
    in_ch.valid   <= 1'b1;
    in_ch.cmd     <= op;
    in_ch.key     <= k;
    in_ch.payload <= p;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    // model always advances; a typed row overrides only the expectation
    pred = apply_table_op(op, k, p);
    pending_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic idle_for(int gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold the sender off until the block has answered everything
  task automatic wait_all_answered();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // result sink: random stalls, some long ones, and calm stretches
  int stall_left = 0;
  int calm_left  = 0;

  always @(posedge clk) begin
    int r;
    if (calm_left > 0) begin
      calm_left--;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
      r = $urandom_range(0, 99);
      if (r < 3) calm_left = $urandom_range(100, 600);
      else if (r < 6) stall_left = $urandom_range(20, 80);
      else if (r < 40) stall_left = $urandom_range(1, 4);
    end
  end

  // result checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_ch.ok !== want.ok) begin
          $error("ok mismatch: expected %0d, actual %0d", want.ok, out_ch.ok);
          error_count++;
        end
        if (out_ch.position !== want.position) begin
          $error("position mismatch: expected %0d, actual %0d",
                 want.position, out_ch.position);
          error_count++;
        end
        if (out_ch.payload_out !== want.payload_out) begin
          $error("payload_out mismatch: expected %h, actual %h",
                 want.payload_out, out_ch.payload_out);
          error_count++;
        end
        if (out_ch.count !== want.count) begin
          $error("count mismatch: expected %0d, actual %0d", want.count, out_ch.count);
          error_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sorted_key_table");
      $finish;
    end
  end

  initial begin
    phase_kind_t      kind;
    logic [CMD_W-1:0] op;
    logic [KEY_W-1:0] k;
    bit               calm;
    int               random_sent;
    int               phase;
    int               steps;
    int               extra;

    in_ch.valid   = 1'b0;
    in_ch.cmd     = CMD_INSERT;
    in_ch.key     = '0;
    in_ch.payload = '0;
    out_ch.ready  = 1'b0;

    // key pool holds the extremes and a few names, so duplicates are common
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = make_name_key();

    // directed rows: empty table, extremes, duplicates, misses, unused code
    // "ALICE" and "ZED" packed first character on top
    dir_rows.push_back('{CMD_SEARCH, 64'h0, 16'h0, 1'b1, '{1'b0, 6'd0, 16'h0, 7'd0}});
    dir_rows.push_back('{CMD_REMOVE, 64'h0, 16'h0, 1'b1, '{1'b0, 6'd0, 16'h0, 7'd0}});
    dir_rows.push_back('{CMD_UNUSED, 64'h0, 16'h0, 1'b1, '{1'b0, 6'd0, 16'h0, 7'd0}});
    dir_rows.push_back('{CMD_INSERT, '1, 16'hffff, 1'b1, '{1'b1, 6'd0, 16'hffff, 7'd1}});
    dir_rows.push_back('{CMD_INSERT, 64'h0, 16'h0, 1'b1, '{1'b1, 6'd0, 16'h0, 7'd2}});
    dir_rows.push_back('{CMD_INSERT, 64'h414c_4943_4500_0000, 16'h1234, 1'b1,
                         '{1'b1, 6'd1, 16'h1234, 7'd3}});
    // equal key lands after the stored one
    dir_rows.push_back('{CMD_INSERT, 64'h414c_4943_4500_0000, 16'h5678, 1'b1,
                         '{1'b1, 6'd2, 16'h5678, 7'd4}});
    dir_rows.push_back('{CMD_SEARCH, 64'h414c_4943_4500_0000, 16'h0, 1'b1,
                         '{1'b1, 6'd1, 16'h1234, 7'd4}});
    dir_rows.push_back('{CMD_UNUSED, '1, 16'hffff, 1'b1, '{1'b0, 6'd0, 16'h0, 7'd4}});
    dir_rows.push_back('{CMD_SEARCH, 64'h5a45_4400_0000_0000, 16'h0, 1'b1,
                         '{1'b0, 6'd0, 16'h0, 7'd4}});
    dir_rows.push_back('{CMD_REMOVE, 64'h5a45_4400_0000_0000, 16'h0, 1'b1,
                         '{1'b0, 6'd0, 16'h0, 7'd4}});
    // remove takes the first of the two equal keys
    dir_rows.push_back('{CMD_REMOVE, 64'h414c_4943_4500_0000, 16'h0, 1'b1,
                         '{1'b1, 6'd1, 16'h1234, 7'd3}});
    dir_rows.push_back('{CMD_SEARCH, 64'h414c_4943_4500_0000, 16'h0, 1'b1,
                         '{1'b1, 6'd1, 16'h5678, 7'd3}});
    dir_rows.push_back('{CMD_REMOVE, '1, 16'h0, 1'b1, '{1'b1, 6'd2, 16'hffff, 7'd2}});
    dir_rows.push_back('{CMD_REMOVE, 64'h0, 16'h0, 1'b1, '{1'b1, 6'd0, 16'h0, 7'd1}});
    dir_rows.push_back('{CMD_REMOVE, 64'h414c_4943_4500_0000, 16'h0, 1'b1,
                         '{1'b1, 6'd0, 16'h5678, 7'd0}});
    // top bit set must sort above top bit clear (unsigned order)
    dir_rows.push_back('{CMD_INSERT, 64'h8000_0000_0000_0000, 16'h8000, 1'b1,
                         '{1'b1, 6'd0, 16'h8000, 7'd1}});
    dir_rows.push_back('{CMD_INSERT, 64'h7fff_ffff_ffff_ffff, 16'h7fff, 1'b1,
                         '{1'b1, 6'd0, 16'h7fff, 7'd2}});
    dir_rows.push_back('{CMD_SEARCH, 64'h8000_0000_0000_0000, 16'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_INSERT, 64'h8000_0000_0000_0001, 16'ha5a5, 1'b0, '0});
    dir_rows.push_back('{CMD_REMOVE, 64'h7fff_ffff_ffff_ffff, 16'h0, 1'b0, '0});
    dir_rows.push_back('{CMD_SEARCH, 64'h8000_0000_0000_0001, 16'h0, 1'b0, '0});

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      send_op(dir_rows[i].cmd, dir_rows[i].key, dir_rows[i].payload,
              dir_rows[i].typed, dir_rows[i].res);
      idle_for(pick_gap(1'b0));
    end
    wait_all_answered();

    // random part in phases; the first two walk the table to full and back
    // to empty so full inserts and misses on an emptied table show up early
    random_sent = 0;
    phase       = 0;
    while (random_sent < RANDOM_ITEMS) begin
      if (phase == 0) kind = PH_FILL;
      else if (phase == 1) kind = PH_DRAIN;
      else kind = phase_kind_t'($urandom_range(0, 2));
      calm  = ($urandom_range(0, 4) == 0);
      steps = 0;
      extra = 0;
      while (steps < 200 && extra < 4 && random_sent < RANDOM_ITEMS) begin
        op = pick_cmd(kind);
        k  = pick_key(op);
        send_op(op, k, 16'($urandom), 1'b0, '0);
        if (op != CMD_UNUSED) random_sent++;
        steps++;
        // a few more after the target, to press on the full or empty table
        if ((kind == PH_FILL && tbl_count == TABLE_DEPTH) ||
            (kind == PH_DRAIN && tbl_count == 0) ||
            (kind == PH_MIX && steps >= 40))
          extra++;
        idle_for(pick_gap(calm));
      end
      if (phase == 0 || $urandom_range(0, 2) == 0) wait_all_answered();
      phase++;
    end

    wait_all_answered();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("PASS sorted_key_table");
    end else begin
      $display("FAIL sorted_key_table");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/skt_pkg.sv
rtl/core/skt_in_if.sv
rtl/core/skt_out_if.sv
rtl/core/skt_ram.sv
rtl/core/skt_cmp.sv
rtl/core/sorted_key_table.sv
tb/testbench.sv
